FILE: hw/rtl/dwdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwdp_pkg
// Shared types and fixed constants of the two-channel wavetable DDS core.
// ----------------------------------------------------------------------------
package dwdp_pkg;

    // field and register widths
    localparam int STEP_W    = 26;
    localparam int WORD_W    = 16;
    localparam int TOP_W     = 16;
    localparam int IN_IDX_W  = 10;
    localparam int ADC_W     = 12;
    localparam int VOL_W     = 5;
    localparam int APB_W     = 32;
    localparam int APB_ADDR_W = 4;

    // phase accumulator, added one byte per cycle
    localparam int PHASE_W      = 32;
    localparam int PHASE_INT_W  = 16;
    localparam int DIGIT_W      = 8;
    localparam int PHASE_DIGITS = PHASE_W / DIGIT_W;
    localparam int PHASE_CNT_W  = $clog2(PHASE_DIGITS);

    // sample times pwm_top, one nibble of pwm_top per cycle
    localparam int MUL_DIGIT_W = 4;
    localparam int MUL_DIGITS  = TOP_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);
    localparam int ACC_W       = WORD_W + 1;

    // volume scaling: x * vol / 20 = ((x * vol) >> 2) / 5, and /5 by reciprocal
    localparam int VPROD_W     = WORD_W + VOL_W;
    localparam int QUART_W     = VPROD_W - 2;
    localparam int RECIP_SHIFT = 21;
    localparam logic [QUART_W-1:0] RECIP_FIVE = 19'd419431;

    // volume control
    localparam logic [VOL_W-1:0] VOL_FULL = 5'd20;
    localparam logic [VOL_W-1:0] VOL_HYST = 5'd2;
    localparam logic [ADC_W+2:0] ADC_ROUND = 15'd512;
    localparam int ADC_SHIFT = 10;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_ADC  = 2'd2
    } dwdp_cmd_t;

    typedef enum logic [1:0] {
        REG_STEP_A  = 2'd0,
        REG_STEP_B  = 2'd1,
        REG_PWM_TOP = 2'd2
    } dwdp_reg_t;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_PHASE,
        TS_READ,
        TS_SCALE,
        TS_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADD,
        PH_WRAP,
        PH_REDUCE,
        PH_DONE
    } phase_state_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL,
        SC_VOL,
        SC_DIV,
        SC_DONE
    } scale_state_t;

endpackage

FILE: hw/rtl/dwdp_wave_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwdp_wave_ram
// Waveform table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module dwdp_wave_ram
    import dwdp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [IDX_W-1:0]  rd_addr_a,
    input  logic [IDX_W-1:0]  rd_addr_b,
    output logic [WORD_W-1:0] rd_data_a,
    output logic [WORD_W-1:0] rd_data_b
);

    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: hw/rtl/dwdp_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwdp_phase
// Two phase accumulators added a byte per cycle, wrapped once at the table
// length, then the integer part reduced to a table index by restoring steps.
// ----------------------------------------------------------------------------
module dwdp_phase
    import dwdp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [STEP_W-1:0] step_a,
    input  logic [STEP_W-1:0] step_b,
    output logic              done,
    output logic [IDX_W-1:0]  addr_a,
    output logic [IDX_W-1:0]  addr_b
);

    localparam int DEPTH_BITS = $clog2(TABLE_DEPTH + 1);
    localparam int RED_STEPS  = PHASE_INT_W + 1 - DEPTH_BITS;
    localparam int RED_CNT_W  = $clog2(RED_STEPS);
    localparam logic [PHASE_INT_W-1:0] DEPTH_INT = PHASE_INT_W'(TABLE_DEPTH);
    localparam logic [PHASE_INT_W-1:0] DIV_INIT =
        PHASE_INT_W'(TABLE_DEPTH << (RED_STEPS - 1));

    phase_state_t state_reg, state_next;

    logic [PHASE_W-1:0]     phase_a_reg, phase_a_next;
    logic [PHASE_W-1:0]     phase_b_reg, phase_b_next;
    logic [PHASE_W-1:0]     sa_reg, sa_next;
    logic [PHASE_W-1:0]     sb_reg, sb_next;
    logic                   carry_a_reg, carry_a_next;
    logic                   carry_b_reg, carry_b_next;
    logic [PHASE_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [PHASE_INT_W-1:0] red_a_reg, red_a_next;
    logic [PHASE_INT_W-1:0] red_b_reg, red_b_next;
    logic [PHASE_INT_W-1:0] div_reg, div_next;
    logic [RED_CNT_W-1:0]   rcnt_reg, rcnt_next;

    logic [DIGIT_W:0]       dsum_a, dsum_b;
    logic [PHASE_INT_W-1:0] hi_a, hi_b, wrap_a, wrap_b;
    logic                   add_last, red_last;

    assign add_last = (dcnt_reg == PHASE_CNT_W'(PHASE_DIGITS - 1));
    assign red_last = (rcnt_reg == RED_CNT_W'(RED_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            PH_IDLE:   if (start) state_next = PH_ADD;
            PH_ADD:    if (add_last) state_next = PH_WRAP;
            PH_WRAP:   state_next = PH_REDUCE;
            PH_REDUCE: if (red_last) state_next = PH_DONE;
            PH_DONE:   state_next = PH_IDLE;
            default:   state_next = PH_IDLE;
        endcase
    end

    always_comb begin
        dsum_a = {1'b0, phase_a_reg[DIGIT_W-1:0]} + {1'b0, sa_reg[DIGIT_W-1:0]}
                 + (DIGIT_W + 1)'(carry_a_reg);
        dsum_b = {1'b0, phase_b_reg[DIGIT_W-1:0]} + {1'b0, sb_reg[DIGIT_W-1:0]}
                 + (DIGIT_W + 1)'(carry_b_reg);
        hi_a   = phase_a_reg[PHASE_W-1 -: PHASE_INT_W];
        hi_b   = phase_b_reg[PHASE_W-1 -: PHASE_INT_W];
        wrap_a = (hi_a >= DEPTH_INT) ? hi_a - DEPTH_INT : hi_a;
        wrap_b = (hi_b >= DEPTH_INT) ? hi_b - DEPTH_INT : hi_b;

        phase_a_next = phase_a_reg;
        phase_b_next = phase_b_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        carry_a_next = carry_a_reg;
        carry_b_next = carry_b_reg;
        dcnt_next    = dcnt_reg;
        red_a_next   = red_a_reg;
        red_b_next   = red_b_reg;
        div_next     = div_reg;
        rcnt_next    = rcnt_reg;

        unique case (state_reg)
            PH_IDLE: begin
                sa_next      = PHASE_W'(step_a);
                sb_next      = PHASE_W'(step_b);
                carry_a_next = 1'b0;
                carry_b_next = 1'b0;
                dcnt_next    = '0;
            end
            PH_ADD: begin
                // rotate the sum byte in at the top, low byte first
                phase_a_next = {dsum_a[DIGIT_W-1:0], phase_a_reg[PHASE_W-1:DIGIT_W]};
                phase_b_next = {dsum_b[DIGIT_W-1:0], phase_b_reg[PHASE_W-1:DIGIT_W]};
                sa_next      = sa_reg >> DIGIT_W;
                sb_next      = sb_reg >> DIGIT_W;
                carry_a_next = dsum_a[DIGIT_W];
                carry_b_next = dsum_b[DIGIT_W];
                dcnt_next    = dcnt_reg + 1'b1;
            end
            PH_WRAP: begin
                phase_a_next = {wrap_a, phase_a_reg[PHASE_W-PHASE_INT_W-1:0]};
                phase_b_next = {wrap_b, phase_b_reg[PHASE_W-PHASE_INT_W-1:0]};
                red_a_next   = wrap_a;
                red_b_next   = wrap_b;
                div_next     = DIV_INIT;
                rcnt_next    = '0;
            end
            PH_REDUCE: begin
                if (red_a_reg >= div_reg) red_a_next = red_a_reg - div_reg;
                if (red_b_reg >= div_reg) red_b_next = red_b_reg - div_reg;
                div_next  = div_reg >> 1;
                rcnt_next = rcnt_reg + 1'b1;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        done   = (state_reg == PH_DONE);
        addr_a = red_a_reg[IDX_W-1:0];
        addr_b = red_b_reg[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= PH_IDLE;
            phase_a_reg <= '0;
            phase_b_reg <= '0;
        end else begin
            state_reg   <= state_next;
            phase_a_reg <= phase_a_next;
            phase_b_reg <= phase_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        carry_a_reg <= carry_a_next;
        carry_b_reg <= carry_b_next;
        dcnt_reg    <= dcnt_next;
        red_a_reg   <= red_a_next;
        red_b_reg   <= red_b_next;
        div_reg     <= div_next;
        rcnt_reg    <= rcnt_next;
    end

endmodule

FILE: hw/rtl/dwdp_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwdp_scale
// Average two samples, scale by pwm_top/65536 a nibble per cycle, then apply
// the volume level in twentieths.
// ----------------------------------------------------------------------------
module dwdp_scale
    import dwdp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] word_a,
    input  logic [WORD_W-1:0] word_b,
    input  logic [TOP_W-1:0]  pwm_top,
    input  logic [VOL_W-1:0]  volume,
    output logic              done,
    output logic [WORD_W-1:0] duty
);

    localparam int PART_W = WORD_W + MUL_DIGIT_W;
    localparam int SUM_W  = PART_W + 1;
    localparam int QPROD_W = 2 * QUART_W;

    scale_state_t state_reg, state_next;

    logic [WORD_W-1:0]    samp_reg, samp_next;
    logic [TOP_W-1:0]     top_sh_reg, top_sh_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VPROD_W-1:0]   vprod_reg, vprod_next;
    logic [WORD_W-1:0]    duty_reg, duty_next;

    logic [WORD_W:0]      pair_sum;
    logic [PART_W-1:0]    part;
    logic [SUM_W-1:0]     acc_sum;
    logic [QPROD_W-1:0]   qprod;
    logic                 mul_last;

    assign mul_last = (cnt_reg == MUL_CNT_W'(MUL_DIGITS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SC_IDLE: if (start) state_next = SC_MUL;
            SC_MUL:  if (mul_last) state_next = SC_VOL;
            SC_VOL:  state_next = SC_DIV;
            SC_DIV:  state_next = SC_DONE;
            SC_DONE: state_next = SC_IDLE;
            default: state_next = SC_IDLE;
        endcase
    end

    always_comb begin
        pair_sum = {1'b0, word_a} + {1'b0, word_b};
        part     = PART_W'(samp_reg) * PART_W'(top_sh_reg[MUL_DIGIT_W-1:0]);
        acc_sum  = SUM_W'(acc_reg) + SUM_W'(part);
        qprod    = QPROD_W'(vprod_reg[VPROD_W-1:2]) * QPROD_W'(RECIP_FIVE);

        samp_next   = samp_reg;
        top_sh_next = top_sh_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        vprod_next  = vprod_reg;
        duty_next   = duty_reg;

        unique case (state_reg)
            SC_IDLE: begin
                samp_next   = pair_sum[WORD_W:1];
                top_sh_next = pwm_top;
                acc_next    = '0;
                cnt_next    = '0;
            end
            SC_MUL: begin
                // drop the low nibble each step; four steps leave product >> 16
                acc_next    = acc_sum[SUM_W-1:MUL_DIGIT_W];
                top_sh_next = top_sh_reg >> MUL_DIGIT_W;
                cnt_next    = cnt_reg + 1'b1;
            end
            SC_VOL: begin
                vprod_next = VPROD_W'(acc_reg[WORD_W-1:0]) * VPROD_W'(volume);
            end
            SC_DIV: begin
                duty_next = qprod[RECIP_SHIFT +: WORD_W];
            end
            SC_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        done = (state_reg == SC_DONE);
        duty = duty_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_reg   <= samp_next;
        top_sh_reg <= top_sh_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        vprod_reg  <= vprod_next;
        duty_reg   <= duty_next;
    end

endmodule

FILE: hw/rtl/dual_wavetable_dds_pwm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wavetable_dds_pwm_core
// Two-channel wavetable oscillator producing a PWM compare value.
// Load and ADC commands complete on transfer and may follow back to back.
// A sample tick passes through the byte-serial phase adder, the wrap, the
// R = 17 - clog2(TABLE_DEPTH + 1) index reduction steps, the table read,
// the nibble multiplier and the volume scaling before its result is registered.
// The next item is taken after the tick's result reaches the output register.
// Reset clears phases and config registers, sets full volume; table undefined.
// ----------------------------------------------------------------------------
module dual_wavetable_dds_pwm_core
    import dwdp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // command channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic [IN_IDX_W-1:0]   s_table_index,
    input  logic [WORD_W-1:0]     s_table_word,
    input  logic [ADC_W-1:0]      s_adc_sample,

    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORD_W-1:0]     m_duty_value,

    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]      prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    top_state_t state_reg, state_next;

    // configuration and volume state
    logic [STEP_W-1:0] step_a_reg, step_a_next;
    logic [STEP_W-1:0] step_b_reg, step_b_next;
    logic [TOP_W-1:0]  pwm_top_reg, pwm_top_next;
    logic [VOL_W-1:0]  volume_reg, volume_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_duty_reg, m_duty_next;

    logic              s_xfer;
    dwdp_cmd_t         cmd;
    logic              cfg_wr;
    dwdp_reg_t         cfg_sel;

    logic              ph_start, ph_done;
    logic              sc_start, sc_done;
    logic              out_load;
    logic [IDX_W-1:0]  addr_a, addr_b;
    logic [WORD_W-1:0] word_a, word_b;
    logic [WORD_W-1:0] duty;

    logic              ram_we;
    logic [31:0]       idx_ext;
    logic [IDX_W-1:0]  ram_waddr;

    logic [ADC_W+2:0]  adc_x5;
    logic [VOL_W-1:0]  level;
    logic [VOL_W-1:0]  level_diff;

    assign pready  = 1'b1;
    assign s_xfer  = s_valid && s_ready;
    assign cmd     = dwdp_cmd_t'(s_command);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = dwdp_reg_t'(paddr[3:2]);

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            TS_IDLE:  if (s_xfer && cmd == CMD_TICK) state_next = TS_PHASE;
            TS_PHASE: if (ph_done) state_next = TS_READ;
            TS_READ:  state_next = TS_SCALE;
            TS_SCALE: if (sc_done) state_next = TS_OUT;
            TS_OUT:   if (!m_valid_reg || m_ready) state_next = TS_IDLE;
            default:  state_next = TS_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == TS_IDLE);
        ph_start = (state_reg == TS_IDLE) && s_xfer && (cmd == CMD_TICK);
        // table data for the indexes shown in the phase done cycle is valid here
        sc_start = (state_reg == TS_READ);
        out_load = (state_reg == TS_OUT) && (!m_valid_reg || m_ready);
    end

    // ------------------------------------------------------------ table writes
    // drop loads whose index lies past the table
    always_comb begin
        idx_ext   = 32'(s_table_index);
        ram_waddr = idx_ext[IDX_W-1:0];
        ram_we    = s_xfer && (cmd == CMD_LOAD) && (idx_ext < 32'(TABLE_DEPTH));
    end

    // ------------------------------------------------------------ volume control
    // level = round(adc * 20 / 4096) = (adc * 5 + 512) >> 10, held with hysteresis
    always_comb begin
        adc_x5      = {s_adc_sample, 2'b00} + (ADC_W + 3)'(s_adc_sample);
        level       = 5'((adc_x5 + ADC_ROUND) >> ADC_SHIFT);
        level_diff  = (level > volume_reg) ? level - volume_reg : volume_reg - level;
        volume_next = volume_reg;
        if (s_xfer && cmd == CMD_ADC && level_diff > VOL_HYST) begin
            volume_next = level;
        end
    end

    // --------------------------------------------------------- configuration
    always_comb begin
        step_a_next  = step_a_reg;
        step_b_next  = step_b_reg;
        pwm_top_next = pwm_top_reg;
        if (cfg_wr) begin
            unique case (cfg_sel)
                REG_STEP_A:  step_a_next  = pwdata[STEP_W-1:0];
                REG_STEP_B:  step_b_next  = pwdata[STEP_W-1:0];
                REG_PWM_TOP: pwm_top_next = pwdata[TOP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_STEP_A:  prdata = APB_W'(step_a_reg);
            REG_STEP_B:  prdata = APB_W'(step_b_reg);
            REG_PWM_TOP: prdata = APB_W'(pwm_top_reg);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------ result output
    // hold the result until the downstream transfer; a new one loads only when free
    always_comb begin
        m_duty_next  = out_load ? duty : m_duty_reg;
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign m_valid      = m_valid_reg;
    assign m_duty_value = m_duty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= TS_IDLE;
            step_a_reg  <= '0;
            step_b_reg  <= '0;
            pwm_top_reg <= '0;
            volume_reg  <= VOL_FULL;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_a_reg  <= step_a_next;
            step_b_reg  <= step_b_next;
            pwm_top_reg <= pwm_top_next;
            volume_reg  <= volume_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_duty_reg <= m_duty_next;
    end

    // -------------------------------------------------------------- datapath
    // advance both phases and reduce them to table indexes
    dwdp_phase #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_phase (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ph_start),
        .step_a  (step_a_reg),
        .step_b  (step_b_reg),
        .done    (ph_done),
        .addr_a  (addr_a),
        .addr_b  (addr_b)
    );

    dwdp_wave_ram #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_wave_ram (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (s_table_word),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (word_a),
        .rd_data_b (word_b)
    );

    // average, scale to the PWM period and apply volume
    dwdp_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sc_start),
        .word_a  (word_a),
        .word_b  (word_b),
        .pwm_top (pwm_top_reg),
        .volume  (volume_reg),
        .done    (sc_done),
        .duty    (duty)
    );

endmodule
